// ===== rtl/aging_hash_slot_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the aging hash slot table
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef AGING_HASH_SLOT_TABLE_ASSERT_SVH
`define AGING_HASH_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define AHST_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("ahst assertion failed");
`define AHST_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ahst implication failed");
`else
`define AHST_ASSERT(label, clk, rstn, prop)
`define AHST_IMPLIES(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/ahst_pkg.sv =====
// ----------------------------------------------------------------------------
// ahst_pkg
// Shared constants and codes for the aging hash slot table.
// ----------------------------------------------------------------------------
package ahst_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int MAX_PROBES_DEF = 32;

    localparam int KEY_W    = 32;
    localparam int STAMP_W  = 32;
    localparam int AGE_W    = 8;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOTOUT_W = 10;
    localparam int ENTRY_W  = KEY_W + STAMP_W;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FRAME  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLAIMED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RECLAIMED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic        REG_STALE_AGE = 1'b0;
    localparam logic [AGE_W-1:0]   STALE_AGE_RST = 8'd2;
    localparam logic [STAMP_W-1:0] FRAME_RST     = 32'd1;

endpackage

// ===== rtl/aging_hash_slot_table.sv =====
// ----------------------------------------------------------------------------
// aging_hash_slot_table
// Linear-probing slot table with frame aging and stale-slot reclaim.
// A lookup is accepted, probes P slots (1 to MAX_PROBES) and then sends its result;
// a zero key is answered without probing, and a frame advance needs no probe.
// A new word is taken only after the last lookup has handed its result to the output
// register; the single read port of the slot memory visits one slot per cycle.
// Reset: a clearing pass zeroes the slot memory; no word is
// accepted until it ends. Configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module aging_hash_slot_table #(
    parameter int SLOTS      = ahst_pkg::SLOTS_DEF,
    parameter int MAX_PROBES = ahst_pkg::MAX_PROBES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[1:0], key[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slot_index[9:0], status[11:10], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(SLOTS);

    logic [ahst_pkg::AGE_W-1:0]     stale_age;
    logic [ahst_pkg::SLOTOUT_W-1:0] out_slot;
    logic [ahst_pkg::STATUS_W-1:0]  out_status;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    logic [IDX_W-1:0]               mem_raddr;
    logic [ahst_pkg::ENTRY_W-1:0]   mem_wdata;
    logic [ahst_pkg::ENTRY_W-1:0]   mem_rdata;

    ahst_apb u_apb (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .stale_age (stale_age)
    );

    ahst_ram #(
        .WIDTH (ahst_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ahst_ctrl #(
        .SLOTS      (SLOTS),
        .MAX_PROBES (MAX_PROBES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stale_age  (stale_age),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_func    (s_tdata[1:0]),
        .in_key     (s_tdata[33:2]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_slot   (out_slot),
        .out_status (out_status),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    assign m_tdata = {4'd0, out_status, out_slot};

endmodule

// ===== rtl/ahst_ram.sv =====
// ----------------------------------------------------------------------------
// ahst_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ahst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ahst_apb.sv =====
// ----------------------------------------------------------------------------
// ahst_apb
// Configuration register file: stale age.
// ----------------------------------------------------------------------------
module ahst_apb (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [ahst_pkg::AGE_W-1:0] stale_age
);

    logic [ahst_pkg::AGE_W-1:0] stale_age_reg;
    logic [ahst_pkg::AGE_W-1:0] stale_age_next;
    logic                       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == ahst_pkg::REG_STALE_AGE);

    always_comb begin
        stale_age_next = stale_age_reg;
        if (wr_hit) begin
            stale_age_next = pwdata[ahst_pkg::AGE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_age_reg <= ahst_pkg::STALE_AGE_RST;
        end else begin
            stale_age_reg <= stale_age_next;
        end
    end

    assign prdata    = (paddr[2] == ahst_pkg::REG_STALE_AGE)
                       ? {{(32-ahst_pkg::AGE_W){1'b0}}, stale_age_reg} : 32'd0;
    assign stale_age = stale_age_reg;

endmodule

// ===== rtl/ahst_ctrl.sv =====
// ----------------------------------------------------------------------------
// ahst_ctrl
// Probe sequencer: clears the slot memory, walks the probe chain one slot
// per cycle, writes back the chosen slot and drives the result word.
// ----------------------------------------------------------------------------
`include "aging_hash_slot_table_assert.svh"

module ahst_ctrl #(
    parameter int SLOTS      = ahst_pkg::SLOTS_DEF,
    parameter int MAX_PROBES = ahst_pkg::MAX_PROBES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ahst_pkg::AGE_W-1:0]    stale_age,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ahst_pkg::FUNC_W-1:0]   in_func,
    input  logic [ahst_pkg::KEY_W-1:0]    in_key,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ahst_pkg::SLOTOUT_W-1:0] out_slot,
    output logic [ahst_pkg::STATUS_W-1:0] out_status,
    output logic                          mem_we,
    output logic [$clog2(SLOTS)-1:0]      mem_waddr,
    output logic [ahst_pkg::ENTRY_W-1:0]  mem_wdata,
    output logic [$clog2(SLOTS)-1:0]      mem_raddr,
    input  logic [ahst_pkg::ENTRY_W-1:0]  mem_rdata
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int PW    = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(SLOTS - 1);
    localparam logic [PW-1:0]    LAST_PROBE = PW'(MAX_PROBES - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [IDX_W-1:0]               clr_reg, clr_next;
    logic [IDX_W-1:0]               rd_reg, rd_next;
    logic [PW-1:0]                  cnt_reg, cnt_next;
    logic                           touch_reg, touch_next;
    logic [ahst_pkg::KEY_W-1:0]     key_reg, key_next;
    logic                           hs_reg, hs_next;
    logic [IDX_W-1:0]               sidx_reg, sidx_next;
    logic [ahst_pkg::STAMP_W-1:0]   slu_reg, slu_next;
    logic [IDX_W-1:0]               hit_reg, hit_next;
    logic [ahst_pkg::STAMP_W-1:0]   hlu_reg, hlu_next;
    logic [ahst_pkg::STATUS_W-1:0]  st_reg, st_next;
    logic                           wb_reg, wb_next;
    logic [ahst_pkg::STAMP_W-1:0]   frame_reg, frame_next;
    logic                           ov_reg, ov_next;
    logic [ahst_pkg::SLOTOUT_W-1:0] oslot_reg, oslot_next;
    logic [ahst_pkg::STATUS_W-1:0]  ost_reg, ost_next;

    logic [ahst_pkg::KEY_W-1:0]     d_key;
    logic [ahst_pkg::STAMP_W-1:0]   d_lu;
    logic [ahst_pkg::STAMP_W:0]     due;
    logic                           stale_now;
    logic                           take_stale;
    logic                           out_free;
    logic [31:0]                    hit_ext;

    assign d_key      = mem_rdata[ahst_pkg::KEY_W-1:0];
    assign d_lu       = mem_rdata[ahst_pkg::ENTRY_W-1:ahst_pkg::KEY_W];
    assign due        = {1'b0, d_lu} + {{(ahst_pkg::STAMP_W+1-ahst_pkg::AGE_W){1'b0}}, stale_age};
    assign stale_now  = due <= {1'b0, frame_reg};
    assign take_stale = !hs_reg && stale_now;
    assign out_free   = !ov_reg || m_tready;
    assign hit_ext    = {{(32-IDX_W){1'b0}}, hit_reg};
    assign s_tready   = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        rd_next    = rd_reg;
        cnt_next   = cnt_reg;
        touch_next = touch_reg;
        key_next   = key_reg;
        hs_next    = hs_reg;
        sidx_next  = sidx_reg;
        slu_next   = slu_reg;
        hit_next   = hit_reg;
        hlu_next   = hlu_reg;
        st_next    = st_reg;
        wb_next    = wb_reg;
        frame_next = frame_reg;
        ov_next    = ov_reg && !m_tready;
        oslot_next = oslot_reg;
        ost_next   = ost_reg;
        mem_we     = 1'b0;
        mem_waddr  = hit_reg;
        mem_wdata  = {(touch_reg ? frame_reg : hlu_reg), key_reg};
        mem_raddr  = rd_reg + 1'b1;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_raddr = in_key[IDX_W-1:0];
                if (s_tvalid) begin
                    case (in_func)
                        ahst_pkg::FUNC_FRAME: begin
                            frame_next = (frame_reg == '1) ? ahst_pkg::FRAME_RST
                                                           : frame_reg + 1'b1;
                        end
                        ahst_pkg::FUNC_LOOKUP, ahst_pkg::FUNC_TOUCH: begin
                            touch_next = (in_func == ahst_pkg::FUNC_TOUCH);
                            key_next   = in_key;
                            rd_next    = in_key[IDX_W-1:0];
                            cnt_next   = '0;
                            hs_next    = 1'b0;
                            if (in_key == '0) begin
                                hit_next   = '0;
                                st_next    = ahst_pkg::ST_FULL;
                                wb_next    = 1'b0;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_PROBE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PROBE: begin
                rd_next  = rd_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (d_key == key_reg) begin
                    hit_next   = rd_reg;
                    hlu_next   = d_lu;
                    st_next    = ahst_pkg::ST_FOUND;
                    wb_next    = touch_reg;
                    state_next = S_DONE;
                end else if (d_lu == '0) begin
                    hit_next   = rd_reg;
                    hlu_next   = d_lu;
                    st_next    = ahst_pkg::ST_CLAIMED;
                    wb_next    = 1'b1;
                    state_next = S_DONE;
                end else begin
                    if (take_stale) begin
                        hs_next   = 1'b1;
                        sidx_next = rd_reg;
                        slu_next  = d_lu;
                    end
                    if (cnt_reg == LAST_PROBE) begin
                        state_next = S_DONE;
                        if (hs_reg || take_stale) begin
                            hit_next = take_stale ? rd_reg : sidx_reg;
                            hlu_next = take_stale ? d_lu : slu_reg;
                            st_next  = ahst_pkg::ST_RECLAIMED;
                            wb_next  = 1'b1;
                        end else begin
                            hit_next = '0;
                            st_next  = ahst_pkg::ST_FULL;
                            wb_next  = 1'b0;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    mem_we     = wb_reg;
                    ov_next    = 1'b1;
                    oslot_next = hit_ext[ahst_pkg::SLOTOUT_W-1:0];
                    ost_next   = st_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            frame_reg <= ahst_pkg::FRAME_RST;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            frame_reg <= frame_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg    <= rd_next;
        cnt_reg   <= cnt_next;
        touch_reg <= touch_next;
        key_reg   <= key_next;
        hs_reg    <= hs_next;
        sidx_reg  <= sidx_next;
        slu_reg   <= slu_next;
        hit_reg   <= hit_next;
        hlu_reg   <= hlu_next;
        st_reg    <= st_next;
        wb_reg    <= wb_next;
        oslot_reg <= oslot_next;
        ost_reg   <= ost_next;
    end

    assign m_tvalid   = ov_reg;
    assign out_slot   = oslot_reg;
    assign out_status = ost_reg;

    `AHST_IMPLIES(a_no_accept_in_clear, aclk, aresetn, state_reg == S_CLEAR, !s_tready)
    `AHST_IMPLIES(a_write_only_clear_or_done, aclk, aresetn, mem_we,
                  state_reg == S_CLEAR || state_reg == S_DONE)
    `AHST_IMPLIES(a_full_slot_zero, aclk, aresetn,
                  ov_reg && ost_reg == ahst_pkg::ST_FULL, oslot_reg == '0)
    `AHST_ASSERT(a_frame_nonzero, aclk, aresetn, frame_reg != '0)

endmodule
